// ===== src/msc_pkg.sv =====
package msc_pkg;

  // Field widths
  localparam int unsigned CH_W     = 5;
  localparam int unsigned ANGLE_W  = 8;
  localparam int unsigned DELAY_W  = 16;
  localparam int unsigned PULSE_W  = 13;
  localparam int unsigned LIMIT_W  = 12;

  // Fixed values
  localparam logic [PULSE_W-1:0] FULL_OFF    = 13'd4096;
  localparam logic [ANGLE_W-1:0] MAX_ANGLE   = 8'd180;
  localparam logic [ANGLE_W-1:0] HOME_ANGLE  = 8'd90;
  localparam logic [DELAY_W-1:0] RESET_DELAY = 16'd5;

  // floor(2^25 / 180); estimate is exact or one low
  localparam logic [17:0] RECIP       = 18'd186413;
  localparam int unsigned RECIP_SHIFT = 25;

  // Input word kinds
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_MOVE = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_PULSE_MIN  = 2'd0;
  localparam logic [1:0] REG_PULSE_MAX  = 2'd1;
  localparam logic [1:0] REG_IDLE_LIMIT = 2'd2;
  localparam logic [1:0] REG_SLEEP_EN   = 2'd3;

  // Reset values of the configuration registers
  localparam logic [LIMIT_W-1:0] RST_PULSE_MIN  = 12'd150;
  localparam logic [LIMIT_W-1:0] RST_PULSE_MAX  = 12'd600;
  localparam logic [15:0]        RST_IDLE_LIMIT = 16'd3000;

  // Queue depth between front and back
  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic                is_tick;
    logic [CH_W-1:0]     channel;
    logic [ANGLE_W-1:0]  angle;
    logic [DELAY_W-1:0]  delay;
    logic                seq;
  } cmd_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]  pulse_min;
    logic [LIMIT_W-1:0]  pulse_max;
    logic [15:0]         idle_limit;
    logic                sleep_en;
  } cfg_t;

endpackage

// ===== src/msc_if.sv =====
interface msc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [4:0]  channel;
  logic [7:0]  target_angle;
  logic [15:0] step_delay;
  logic        sequence_active;

  modport source (output valid, mode, channel, target_angle, step_delay, sequence_active,
                  input ready);
  modport sink   (input valid, mode, channel, target_angle, step_delay, sequence_active,
                  output ready);
endinterface

interface msc_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  out_channel;
  logic [12:0] pulse;
  logic        last;

  modport source (output valid, out_channel, pulse, last, input ready);
  modport sink   (input valid, out_channel, pulse, last, output ready);
endinterface

interface msc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/msc_front.sv =====
module msc_front #(
  parameter int CHANNELS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  msc_in_if.sink        in_ch,
  output msc_pkg::cmd_t q_cmd,
  output logic          q_valid,
  input  logic          q_ready
);

  logic          hold_v_r;
  msc_pkg::cmd_t hold_r;
  msc_pkg::cmd_t cmd_nxt;
  logic          accept;
  logic          keep;

  assign in_ch.ready = !hold_v_r || q_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // move to a channel past the end is dropped here
  assign keep = (in_ch.mode == msc_pkg::MODE_TICK) ||
                ({1'b0, in_ch.channel} < 6'(CHANNELS));

  always_comb begin
    cmd_nxt.is_tick = in_ch.mode == msc_pkg::MODE_TICK;
    cmd_nxt.channel = in_ch.channel;
    cmd_nxt.angle   = (in_ch.target_angle > msc_pkg::MAX_ANGLE) ? msc_pkg::MAX_ANGLE
                                                                : in_ch.target_angle;
    cmd_nxt.delay   = in_ch.step_delay;
    cmd_nxt.seq     = in_ch.sequence_active;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      if (accept && keep) begin
        hold_v_r <= 1'b1;
        hold_r   <= cmd_nxt;
      end else if (hold_v_r && q_ready) begin
        hold_v_r <= 1'b0;
      end
    end
  end

  assign q_cmd   = hold_r;
  assign q_valid = hold_v_r;

endmodule

// ===== src/msc_queue.sv =====
module msc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  msc_pkg::cmd_t push_cmd,
  input  logic          push_valid,
  output logic          push_ready,
  output msc_pkg::cmd_t pop_cmd,
  output logic          pop_valid,
  input  logic          pop_ready
);

  localparam int PW = (msc_pkg::QDEPTH > 1) ? $clog2(msc_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(msc_pkg::QDEPTH + 1);

  msc_pkg::cmd_t   slot_r [msc_pkg::QDEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = cnt_r != CW'(msc_pkg::QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        slot_r[wr_ptr_r] <= push_cmd;
        wr_ptr_r <= (wr_ptr_r == PW'(msc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(msc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/msc_back.sv =====
module msc_back #(
  parameter int CHANNELS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  msc_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  msc_pkg::cfg_t cfg,
  msc_out_if.source     out_ch
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CH, ST_MUL, ST_DIV, ST_EMIT, ST_OFF, ST_DONE
  } state_t;

  state_t        state_r;
  logic [CW-1:0] ch_r;
  msc_pkg::cmd_t cmd_r;
  logic          all_idle_r;
  logic          asleep_r;
  logic [7:0]    angle_r;
  logic          neg_r;
  logic [19:0]   prod_abs_r;
  logic [12:0]   quo_r;

  logic [7:0]    pos_r [CHANNELS];
  logic [7:0]    tgt_r [CHANNELS];
  logic [15:0]   dly_r [CHANNELS];
  logic [15:0]   el_r  [CHANNELS];

  logic          pend_v_r;
  logic [4:0]    pend_ch_r;
  logic [12:0]   pend_pulse_r;
  logic          out_v_r;
  logic [4:0]    out_ch_r;
  logic [12:0]   out_pulse_r;
  logic          out_last_r;

  // per-channel update
  logic [15:0]   el_cur, el_inc, el_nxt;
  logic [7:0]    pos_cur, tgt_cur, pos_step;
  logic          step, idle_ok, sleep_base, suppress, last_ch, walk_sleep;

  // pulse datapath
  logic signed [12:0] span;
  logic signed [21:0] prod;
  logic [19:0]        prod_abs;
  logic [37:0]        recip_prod;
  logic [20:0]        rem;
  logic [12:0]        quo_fix;
  logic signed [13:0] pulse_s;

  // result staging
  logic          can_push, push, flush;
  logic [12:0]   push_pulse;

  assign el_cur   = el_r[ch_r];
  assign pos_cur  = pos_r[ch_r];
  assign tgt_cur  = tgt_r[ch_r];
  assign el_inc   = (el_cur == 16'hFFFF) ? el_cur : el_cur + 16'd1;
  assign step     = (pos_cur != tgt_cur) && (el_inc >= dly_r[ch_r]);
  assign pos_step = (pos_cur < tgt_cur) ? pos_cur + 8'd1 : pos_cur - 8'd1;
  assign el_nxt   = step ? 16'd0 : el_inc;
  assign idle_ok  = el_nxt >= cfg.idle_limit;
  assign last_ch  = ch_r == LAST_CH;

  // with a zero idle limit the sleep is certain, so step words are held back
  assign sleep_base = cfg.sleep_en && !asleep_r && !cmd_r.seq;
  assign suppress   = sleep_base && (cfg.idle_limit == 16'd0);
  assign walk_sleep = sleep_base && all_idle_r && ((state_r != ST_CH) || idle_ok);

  assign span       = $signed({1'b0, cfg.pulse_max}) - $signed({1'b0, cfg.pulse_min});
  assign prod       = $signed({1'b0, angle_r}) * span;
  assign prod_abs   = prod[21] ? 20'(-prod) : 20'(prod);
  assign recip_prod = prod_abs_r * msc_pkg::RECIP;
  assign rem        = 21'(prod_abs_r) - 21'(quo_r) * 21'(msc_pkg::MAX_ANGLE);
  assign quo_fix    = (rem >= 21'(msc_pkg::MAX_ANGLE)) ? quo_r + 13'd1 : quo_r;
  assign pulse_s    = $signed({2'b00, cfg.pulse_min})
                    + (neg_r ? -$signed({1'b0, quo_fix}) : $signed({1'b0, quo_fix}));

  assign can_push   = !pend_v_r || !out_v_r || out_ch.ready;
  assign push       = can_push && ((state_r == ST_EMIT) || (state_r == ST_OFF));
  assign push_pulse = (state_r == ST_OFF) ? msc_pkg::FULL_OFF : pulse_s[12:0];
  assign flush      = (state_r == ST_DONE) && pend_v_r && (!out_v_r || out_ch.ready);

  assign cmd_ready = state_r == ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ch_r     <= '0;
      asleep_r <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        pos_r[i] <= msc_pkg::HOME_ANGLE;
        tgt_r[i] <= msc_pkg::HOME_ANGLE;
        dly_r[i] <= msc_pkg::RESET_DELAY;
        el_r[i]  <= 16'd0;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            cmd_r      <= cmd;
            ch_r       <= '0;
            all_idle_r <= 1'b1;
            if (cmd.is_tick || asleep_r) begin
              state_r <= ST_CH;
            end else begin
              tgt_r[cmd.channel[CW-1:0]] <= cmd.angle;
              dly_r[cmd.channel[CW-1:0]] <= cmd.delay;
            end
          end
        end
        ST_CH: begin
          if (cmd_r.is_tick) begin
            el_r[ch_r] <= el_nxt;
            all_idle_r <= all_idle_r && idle_ok;
            if (step) begin
              pos_r[ch_r] <= pos_step;
            end
            if (step && !suppress) begin
              angle_r <= pos_step;
              state_r <= ST_MUL;
            end else if (!last_ch) begin
              ch_r <= ch_r + 1'b1;
            end else if (walk_sleep) begin
              ch_r    <= '0;
              state_r <= ST_OFF;
            end else begin
              state_r <= ST_DONE;
            end
          end else begin
            // wake: re-send the current angle
            angle_r <= pos_cur;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          neg_r      <= prod[21];
          prod_abs_r <= prod_abs;
          state_r    <= ST_DIV;
        end
        ST_DIV: begin
          quo_r   <= recip_prod[msc_pkg::RECIP_SHIFT +: 13];
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (can_push) begin
            if (!last_ch) begin
              ch_r    <= ch_r + 1'b1;
              state_r <= ST_CH;
            end else if (!cmd_r.is_tick) begin
              tgt_r[cmd_r.channel[CW-1:0]] <= cmd_r.angle;
              dly_r[cmd_r.channel[CW-1:0]] <= cmd_r.delay;
              asleep_r <= 1'b0;
              state_r  <= ST_DONE;
            end else if (walk_sleep) begin
              ch_r    <= '0;
              state_r <= ST_OFF;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_OFF: begin
          if (can_push) begin
            if (last_ch) begin
              asleep_r <= 1'b1;
              state_r  <= ST_DONE;
            end else begin
              ch_r <= ch_r + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (!pend_v_r || flush) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      // one word is held back so the final one can carry last
      if (push) begin
        pend_v_r     <= 1'b1;
        pend_ch_r    <= 5'(ch_r);
        pend_pulse_r <= push_pulse;
      end else if (flush) begin
        pend_v_r <= 1'b0;
      end

      if ((push && pend_v_r) || flush) begin
        out_v_r     <= 1'b1;
        out_ch_r    <= pend_ch_r;
        out_pulse_r <= pend_pulse_r;
        out_last_r  <= flush;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.out_channel = out_ch_r;
  assign out_ch.pulse       = out_pulse_r;
  assign out_ch.last        = out_last_r;

endmodule

// ===== src/multi_servo_slew_controller.sv =====
// Channel  Dir  Word                                                Handshake
// in_ch    in   mode, channel, target_angle, step_delay,            valid/ready
//               sequence_active
// out_ch   out  out_channel, pulse, last                            valid/ready
// cfg_ch   in   index, data (register write)                        valid/ready, ready tied high
//
// Sequence: a tick takes the word, walks each channel, runs ST_MUL, ST_DIV and ST_EMIT for
//   each channel that sends a pulse, may make an all-off pass (ST_OFF) and closes in ST_DONE;
//   a wake re-sends every channel, and an awake move is taken in ST_IDLE. Output stalls hold these.
// Reset: synchronous, active low; all channels at 90 degrees, delay 5, count 0.
// Stalls: a 2-entry queue parts intake from the back; one word is held before
//   the output register so the last flag is known, and the back waits on out_ch.
module multi_servo_slew_controller #(
  parameter int CHANNELS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  msc_in_if.sink    in_ch,
  msc_out_if.source out_ch,
  msc_cfg_if.sink   cfg_ch
);

  msc_pkg::cfg_t cfg_r;

  msc_pkg::cmd_t fq_cmd;
  logic          fq_valid;
  logic          fq_ready;
  msc_pkg::cmd_t qb_cmd;
  logic          qb_valid;
  logic          qb_ready;

  // config is to change only while the block is idle (the block does not enforce it); writes land at once
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_min  <= msc_pkg::RST_PULSE_MIN;
      cfg_r.pulse_max  <= msc_pkg::RST_PULSE_MAX;
      cfg_r.idle_limit <= msc_pkg::RST_IDLE_LIMIT;
      cfg_r.sleep_en   <= 1'b1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        msc_pkg::REG_PULSE_MIN:  cfg_r.pulse_min  <= cfg_ch.data[11:0];
        msc_pkg::REG_PULSE_MAX:  cfg_r.pulse_max  <= cfg_ch.data[11:0];
        msc_pkg::REG_IDLE_LIMIT: cfg_r.idle_limit <= cfg_ch.data;
        msc_pkg::REG_SLEEP_EN:   cfg_r.sleep_en   <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // front: takes words, drops out-of-range moves, clamps the angle
  msc_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_cmd   (fq_cmd),
    .q_valid (fq_valid),
    .q_ready (fq_ready)
  );

  msc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cmd   (fq_cmd),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .pop_cmd    (qb_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready)
  );

  // back: channel state, stepping, sleep/wake and the pulse datapath
  msc_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (qb_cmd),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cfg       (cfg_r),
    .out_ch    (out_ch)
  );

endmodule
